@@ design/irs_pkg.sv @@
// ============================================================================
// irs_pkg: shared definitions for the interleaved request splitter
// Widths, constants, register indexes and the controller/datapath structs.
// ============================================================================
`default_nettype none

package irs_pkg;

  // Memory layout constants.
  localparam int unsigned BLOCK_BYTES       = 1024;
  localparam int unsigned BLK_BITS          = $clog2(BLOCK_BYTES);
  localparam int unsigned ADDR_W            = 32;
  localparam int unsigned GBLK_W            = ADDR_W - BLK_BITS;
  localparam int unsigned NODES_MAX         = 64;
  localparam int unsigned NODES_W           = 7;
  localparam int unsigned NODE_W            = 6;
  localparam int unsigned LEN_W             = 16;
  localparam int unsigned MAX_REQUEST_BYTES = 32768;
  localparam int unsigned CHUNK_W           = 11;

  // Division sequencer: one quotient bit per cycle.
  localparam int unsigned DIV_STEPS = GBLK_W;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

  // Stream payload widths.
  localparam int unsigned S_TDATA_W = 48;
  localparam int unsigned S_TUSER_W = 1;
  localparam int unsigned M_TDATA_W = 56;
  localparam int unsigned M_TUSER_W = 2;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_NODES  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_NODE = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture a new request and start the division
    logic div_step;  // one restoring division step
    logic emit;      // load the next chunk into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;    // the current division step is the final one
    logic len_zero;    // the request carries no bytes
    logic last_chunk;  // the next chunk finishes the request
    logic out_free;    // the output register can take a beat this cycle
  } sts_t;

endpackage

`default_nettype wire

@@ design/interleaved_request_splitter_core.sv @@
// ============================================================================
// interleaved_request_splitter_core: block-interleaved request splitter
// Splits a (offset, length) request into one chunk per 1024-byte block.
// ============================================================================
// A request is taken on the slave stream and split into one beat per block
// it touches, in ascending address order, with tlast on the final chunk. Each
// beat names the owning node (block index mod node count), the offset inside
// that node's segment and the chunk size. A request occupies the block for
// its capture cycle, a bit-serial restoring divider that splits the 22-bit
// block index by the node count, then N chunks (0 to 33), one chunk per cycle
// while the output register drains. A zero-length request produces no beats.
// The next request is accepted once the last chunk has entered the output
// register.
// Configuration must be written only while no request is in flight.
`default_nettype none

module interleaved_request_splitter_core (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // Configuration write port.
  input  wire logic                               cfg_we_i,
  input  wire logic [irs_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [irs_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // Request stream.
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // tdata: byte_offset[31:0], length[47:32]
  input  wire logic [irs_pkg::S_TDATA_W-1:0]      s_axis_tdata,
  // tuser: req_type[0]
  input  wire logic [irs_pkg::S_TUSER_W-1:0]      s_axis_tuser,
  // Chunk stream.
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // tdata: target_node[5:0], local_offset[37:6], chunk_bytes[48:38], zero[55:49]
  output logic [irs_pkg::M_TDATA_W-1:0]           m_axis_tdata,
  // tuser: direction[0], is_local[1]
  output logic [irs_pkg::M_TUSER_W-1:0]           m_axis_tuser,
  output logic                                    m_axis_tlast
);

  irs_pkg::cmd_t                  cmd;
  irs_pkg::sts_t                  sts;
  logic                           direction;
  logic [irs_pkg::NODE_W-1:0]     target_node;
  logic [irs_pkg::ADDR_W-1:0]     local_offset;
  logic [irs_pkg::CHUNK_W-1:0]    chunk_bytes;
  logic                           is_local;

  // Controller.
  irs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath.
  irs_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .req_type_i     (s_axis_tuser[0]),
    .byte_offset_i  (s_axis_tdata[31:0]),
    .length_i       (s_axis_tdata[47:32]),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .direction_o    (direction),
    .target_node_o  (target_node),
    .local_offset_o (local_offset),
    .chunk_bytes_o  (chunk_bytes),
    .is_local_o     (is_local),
    .last_o         (m_axis_tlast)
  );

  // Pack the output beat.
  assign m_axis_tdata = {7'b0, chunk_bytes, local_offset, target_node};
  assign m_axis_tuser = {is_local, direction};

`ifndef ASSERT_OFF
  // A chunk always carries between one byte and a whole block.
  a_chunk_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[48:38] != 11'd0) && (m_axis_tdata[48:38] <= 11'd1024))
    else $error("chunk size out of range");

  // Every chunk but the last runs exactly to the end of its block.
  a_block_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |->
      (m_axis_tdata[48:38] == (11'd1024 - {1'b0, m_axis_tdata[15:6]})))
    else $error("non-final chunk stops short of a block boundary");

  // An accepted request holds off the next one while it is divided.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request accepted while the previous one is in progress");
`endif

endmodule

`default_nettype wire

@@ design/irs_ctrl.sv @@
// ============================================================================
// irs_ctrl: request splitter controller
// Sequences request capture, the node-count division and chunk emission.
// ============================================================================
`default_nettype none

module irs_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          req_valid_i,
  output logic               req_ready_o,
  input  wire irs_pkg::sts_t sts_i,
  output irs_pkg::cmd_t      cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;

  // Commands follow directly from the state and the status.
  always_comb begin
    state_d          = state_q;
    cmd_o            = '0;
    req_ready_o      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) begin
          state_d = sts_i.len_zero ? ST_IDLE : ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.last_chunk) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

@@ design/irs_datapath.sv @@
// ============================================================================
// irs_datapath: request splitter datapath
// Holds configuration, the request, the block/node divider and the output
// register.
// ============================================================================
`default_nettype none

module irs_datapath (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Configuration writes.
  input  wire logic                             cfg_we_i,
  input  wire logic [irs_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [irs_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // Request fields.
  input  wire logic                             req_type_i,
  input  wire logic [irs_pkg::ADDR_W-1:0]       byte_offset_i,
  input  wire logic [irs_pkg::LEN_W-1:0]        length_i,
  // Controller link.
  input  wire irs_pkg::cmd_t                    cmd_i,
  output irs_pkg::sts_t                         sts_o,
  // Output beat.
  input  wire logic                             out_ready_i,
  output logic                                  out_valid_o,
  output logic                                  direction_o,
  output logic [irs_pkg::NODE_W-1:0]            target_node_o,
  output logic [irs_pkg::ADDR_W-1:0]            local_offset_o,
  output logic [irs_pkg::CHUNK_W-1:0]           chunk_bytes_o,
  output logic                                  is_local_o,
  output logic                                  last_o
);

  localparam int unsigned BW = irs_pkg::BLK_BITS;
  localparam int unsigned GW = irs_pkg::GBLK_W;
  localparam int unsigned NW = irs_pkg::NODES_W;

  // Configuration registers.
  logic [NW-1:0]                 num_nodes_q;
  logic [irs_pkg::NODE_W-1:0]    local_node_q;

  // Request and division state.
  logic                          dir_q;
  logic [GW-1:0]                 gblk_q, gblk_d;
  logic [BW-1:0]                 inblk_q, inblk_d;
  logic [irs_pkg::LEN_W-1:0]     len_q, len_d;
  logic [NW-1:0]                 nodes_q, nodes_d;
  logic [GW-1:0]                 quo_q, quo_d;
  logic [NW-1:0]                 rem_q, rem_d;
  logic [irs_pkg::CNT_W-1:0]     cnt_q, cnt_d;

  // Output register.
  logic                          out_valid_q;
  logic                          direction_q;
  logic [irs_pkg::NODE_W-1:0]    target_node_q;
  logic [irs_pkg::ADDR_W-1:0]    local_offset_q;
  logic [irs_pkg::CHUNK_W-1:0]   chunk_bytes_q;
  logic                          is_local_q;
  logic                          last_q;

  logic [NW-1:0]                 eff_nodes;
  logic [irs_pkg::LEN_W-1:0]     len_clamped;
  logic [NW-1:0]                 trial;
  logic                          qbit;
  logic [irs_pkg::CHUNK_W-1:0]   room;
  logic [irs_pkg::CHUNK_W-1:0]   chunk;
  logic [NW-1:0]                 rem_inc;

  // Node count seen by the divider: zero acts as one, the top is capped.
  always_comb begin
    eff_nodes = num_nodes_q;
    if (num_nodes_q == '0) begin
      eff_nodes = NW'(1);
    end else if (num_nodes_q > NW'(irs_pkg::NODES_MAX)) begin
      eff_nodes = NW'(irs_pkg::NODES_MAX);
    end
  end

  assign len_clamped = (length_i > irs_pkg::LEN_W'(irs_pkg::MAX_REQUEST_BYTES)) ?
                       irs_pkg::LEN_W'(irs_pkg::MAX_REQUEST_BYTES) : length_i;

  // Restoring division step: shift in the next block-index bit.
  assign trial = {rem_q[NW-2:0], quo_q[GW-1]};
  assign qbit  = (trial >= nodes_q);

  // Chunk size: bytes left in the block, capped by the bytes left in the request.
  assign room  = irs_pkg::CHUNK_W'(irs_pkg::BLOCK_BYTES) - irs_pkg::CHUNK_W'(inblk_q);
  assign chunk = (len_q < irs_pkg::LEN_W'(room)) ? irs_pkg::CHUNK_W'(len_q) : room;
  assign rem_inc = rem_q + NW'(1);

  always_comb begin
    gblk_d  = gblk_q;
    inblk_d = inblk_q;
    len_d   = len_q;
    nodes_d = nodes_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    if (cmd_i.load) begin
      gblk_d  = byte_offset_i[irs_pkg::ADDR_W-1:BW];
      inblk_d = byte_offset_i[BW-1:0];
      len_d   = len_clamped;
      nodes_d = eff_nodes;
      quo_d   = byte_offset_i[irs_pkg::ADDR_W-1:BW];
      rem_d   = '0;
      cnt_d   = '0;
    end else if (cmd_i.div_step) begin
      rem_d = qbit ? (trial - nodes_q) : trial;
      quo_d = {quo_q[GW-2:0], qbit};
      cnt_d = cnt_q + irs_pkg::CNT_W'(1);
    end else if (cmd_i.emit) begin
      len_d   = len_q - irs_pkg::LEN_W'(chunk);
      inblk_d = '0;
      gblk_d  = gblk_q + GW'(1);
      // Step to the next block; the address space wraps to block zero.
      if (gblk_q == '1) begin
        rem_d = '0;
        quo_d = '0;
      end else if (rem_inc == nodes_q) begin
        rem_d = '0;
        quo_d = quo_q + GW'(1);
      end else begin
        rem_d = rem_inc;
      end
    end
  end

  // Status back to the controller.
  assign sts_o.div_done   = (cnt_q == irs_pkg::CNT_W'(irs_pkg::DIV_STEPS - 1));
  assign sts_o.len_zero   = (len_q == '0);
  assign sts_o.last_chunk = (len_q == irs_pkg::LEN_W'(chunk));
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_nodes_q  <= NW'(1);
      local_node_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        irs_pkg::REG_NUM_NODES:  num_nodes_q  <= cfg_data_i;
        irs_pkg::REG_LOCAL_NODE: local_node_q <= cfg_data_i[irs_pkg::NODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Request and divider registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dir_q <= req_type_i;
    end
    gblk_q  <= gblk_d;
    inblk_q <= inblk_d;
    len_q   <= len_d;
    nodes_q <= nodes_d;
    quo_q   <= quo_d;
    rem_q   <= rem_d;
    cnt_q   <= cnt_d;
  end

  // Output beat valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output beat payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      direction_q    <= dir_q;
      target_node_q  <= rem_q[irs_pkg::NODE_W-1:0];
      local_offset_q <= {quo_q, inblk_q};
      chunk_bytes_q  <= chunk;
      is_local_q     <= (rem_q[irs_pkg::NODE_W-1:0] == local_node_q);
      last_q         <= (len_q == irs_pkg::LEN_W'(chunk));
    end
  end

  assign out_valid_o    = out_valid_q;
  assign direction_o    = direction_q;
  assign target_node_o  = target_node_q;
  assign local_offset_o = local_offset_q;
  assign chunk_bytes_o  = chunk_bytes_q;
  assign is_local_o     = is_local_q;
  assign last_o         = last_q;

endmodule

`default_nettype wire

@@ tb/interleaved_request_splitter_core_test.sv @@
// ============================================================================
// interleaved_request_splitter_core_test: self-checking regression
// Drives requests into the splitter under random source gaps and sink stalls
// and checks every chunk beat against a block-interleave predictor. A table
// of directed requests comes first, then several phases of random requests,
// each phase under its own node count and local node id.
// ============================================================================
`default_nettype none

module interleaved_request_splitter_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  // Covers the capture and divider cycles of a request that emits nothing.
  localparam int unsigned DRAIN_CYCLES = 48;
  localparam int unsigned PHASES       = 6;
  localparam int unsigned PHASE_ITEMS  = 55;

  // One chunk beat as the sink sees it.
  typedef struct packed {
    logic                           direction;
    logic [irs_pkg::NODE_W-1:0]     target_node;
    logic [irs_pkg::ADDR_W-1:0]     local_offset;
    logic [irs_pkg::CHUNK_W-1:0]    chunk_bytes;
    logic                           is_local;
    logic                           last;
  } chunk_t;

  typedef enum logic {ROW_CFG, ROW_REQ} row_kind_e;

  // One row of the directed table: a register write or a request. A typed
  // row is a single-chunk request whose chunk is given by hand.
  typedef struct {
    row_kind_e                      kind;
    logic [irs_pkg::CFG_IDX_W-1:0]  reg_index;
    logic [irs_pkg::CFG_DATA_W-1:0] reg_value;
    logic                           dir;
    logic [irs_pkg::ADDR_W-1:0]     offset;
    logic [irs_pkg::LEN_W-1:0]      length;
    bit                             typed;
    chunk_t                         chunk;
  } step_t;

  logic                           clk_i;
  logic                           rst_ni        = 1'b0;
  logic                           cfg_we_i      = 1'b0;
  logic [irs_pkg::CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [irs_pkg::CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [irs_pkg::S_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [irs_pkg::S_TUSER_W-1:0]  s_axis_tuser  = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [irs_pkg::M_TDATA_W-1:0]  m_axis_tdata;
  logic [irs_pkg::M_TUSER_W-1:0]  m_axis_tuser;
  logic                           m_axis_tlast;

  // Predictor copy of the configuration registers.
  logic [irs_pkg::CFG_DATA_W-1:0] nodes_cfg = 7'd1;
  logic [irs_pkg::NODE_W-1:0]     home_node = '0;

  chunk_t      pending_chunks[$];
  chunk_t      seen_chunk;
  step_t       directed_rows[$];
  int          mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned burst_left     = 0;

  interleaved_request_splitter_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Split one request into the chunks it must produce, in address order.
  function automatic void split_request(input logic dir,
                                        input logic [irs_pkg::ADDR_W-1:0] offset,
                                        input logic [irs_pkg::LEN_W-1:0] length);
    logic [irs_pkg::ADDR_W-1:0] addr;
    int unsigned                nodes;
    int unsigned                remaining;
    int unsigned                gblock;
    int unsigned                in_block;
    int unsigned                span;
    chunk_t                     c;
    nodes = (nodes_cfg == 0) ? 1 :
            ((nodes_cfg > irs_pkg::NODES_MAX) ? irs_pkg::NODES_MAX : nodes_cfg);
    remaining = (length > irs_pkg::MAX_REQUEST_BYTES) ? irs_pkg::MAX_REQUEST_BYTES : length;
    addr = offset;
    while (remaining > 0) begin
      gblock   = addr / irs_pkg::BLOCK_BYTES;
      in_block = addr % irs_pkg::BLOCK_BYTES;
      span     = irs_pkg::BLOCK_BYTES - in_block;
      if (span > remaining) begin
        span = remaining;
      end
      remaining -= span;
      c.direction    = dir;
      c.target_node  = irs_pkg::NODE_W'(gblock % nodes);
      c.local_offset = (gblock / nodes) * irs_pkg::BLOCK_BYTES + in_block;
      c.chunk_bytes  = irs_pkg::CHUNK_W'(span);
      c.is_local     = (c.target_node == home_node);
      c.last         = (remaining == 0);
      pending_chunks.push_back(c);
      // The running offset is a 32-bit counter and wraps past the top.
      addr = addr + span;
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  function automatic step_t cfg_row(input logic [irs_pkg::CFG_IDX_W-1:0] index,
                                    input logic [irs_pkg::CFG_DATA_W-1:0] value);
    step_t s;
    s.kind      = ROW_CFG;
    s.reg_index = index;
    s.reg_value = value;
    return s;
  endfunction

  function automatic step_t req_row(input logic dir,
                                    input logic [irs_pkg::ADDR_W-1:0] offset,
                                    input logic [irs_pkg::LEN_W-1:0] length);
    step_t s;
    s.kind   = ROW_REQ;
    s.dir    = dir;
    s.offset = offset;
    s.length = length;
    s.typed  = 1'b0;
    return s;
  endfunction

  function automatic step_t typed_row(input logic dir,
                                      input logic [irs_pkg::ADDR_W-1:0] offset,
                                      input logic [irs_pkg::LEN_W-1:0] length,
                                      input logic [irs_pkg::NODE_W-1:0] node,
                                      input logic [irs_pkg::ADDR_W-1:0] local_offset,
                                      input logic is_local);
    step_t s;
    s = req_row(dir, offset, length);
    s.typed = 1'b1;
    s.chunk = '{dir, node, local_offset, length[irs_pkg::CHUNK_W-1:0], is_local, 1'b1};
    return s;
  endfunction

  // Hold the source off until every expected chunk has arrived, then let the
  // block finish any request that emits nothing.
  task automatic drain_chunks(input int unsigned hold);
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_chunks.size() != 0);
    repeat (hold) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [irs_pkg::CFG_IDX_W-1:0] index,
                                input logic [irs_pkg::CFG_DATA_W-1:0] value);
    drain_chunks(DRAIN_CYCLES);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (index == irs_pkg::REG_NUM_NODES) begin
      nodes_cfg = value;
    end else begin
      home_node = value[irs_pkg::NODE_W-1:0];
    end
  endtask

  // Offer one request and record what it must produce once it is taken.
  task automatic send_request(input logic dir, input logic [irs_pkg::ADDR_W-1:0] offset,
                              input logic [irs_pkg::LEN_W-1:0] length, input bit typed,
                              input chunk_t chunk);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {length, offset};
    s_axis_tuser  <= dir;
    do @(posedge clk_i); while (!s_axis_tready);
    if (typed) begin
      pending_chunks.push_back(chunk);
    end else begin
      split_request(dir, offset, length);
    end
    // Source pacing: bursts of random length, random gaps, now and then a
    // full drain of the output side.
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if ($urandom_range(0, 29) == 0) begin
        drain_chunks(0);
      end else if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Sink side: check each accepted beat, then pick the next ready value from
  // a pattern set by bits [8:6] of the cycle counter.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen_chunk = {m_axis_tuser[0], m_axis_tdata[5:0], m_axis_tdata[37:6],
                    m_axis_tdata[48:38], m_axis_tuser[1], m_axis_tlast};
      if (pending_chunks.size() == 0) begin
        $error("chunk beat with no request behind it: tdata 0x%0h", m_axis_tdata);
        mismatch_count++;
      end else begin
        chunk_t want;
        want = pending_chunks.pop_front();
        check_field("direction", 32'(want.direction), 32'(seen_chunk.direction));
        check_field("target_node", 32'(want.target_node), 32'(seen_chunk.target_node));
        check_field("local_offset", want.local_offset, seen_chunk.local_offset);
        check_field("chunk_bytes", 32'(want.chunk_bytes), 32'(seen_chunk.chunk_bytes));
        check_field("is_local", 32'(want.is_local), 32'(seen_chunk.is_local));
        check_field("last", 32'(want.last), 32'(seen_chunk.last));
      end
    end
    case (cycle_count[8:6])
      3'd0, 3'd1, 3'd2: m_axis_tready <= 1'b1;
      3'd3, 3'd4:       m_axis_tready <= ($urandom_range(0, 1) == 1);
      3'd5:             m_axis_tready <= ($urandom_range(0, 3) == 0);
      default:          m_axis_tready <= cycle_count[1];
    endcase
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("interleaved_request_splitter_core regression: fail");
      $finish;
    end
  end

  initial begin
    logic [irs_pkg::ADDR_W-1:0]     offset;
    logic [irs_pkg::LEN_W-1:0]      length;
    logic [irs_pkg::CFG_DATA_W-1:0] nodes;
    logic [irs_pkg::CFG_DATA_W-1:0] home;
    int unsigned                    pick;
    chunk_t                         none;

    none = '0;

    // Directed table. Rows after reset run with one node and local node 0.
    directed_rows.push_back(typed_row(1'b0, 32'h0000_0000, 16'd1, 6'd0, 32'h0000_0000, 1'b1));
    directed_rows.push_back(typed_row(1'b1, 32'h0000_03FF, 16'd1, 6'd0, 32'h0000_03FF, 1'b1));
    // Zero length: nothing comes out.
    directed_rows.push_back(req_row(1'b0, 32'h0000_1234, 16'd0));
    directed_rows.push_back(typed_row(1'b1, 32'hFFFF_FC00, 16'd1024, 6'd0, 32'hFFFF_FC00,
                                      1'b1));
    // The running offset wraps past the top of the space.
    directed_rows.push_back(req_row(1'b0, 32'hFFFF_FF00, 16'h0300));
    // Oversized length is cut to the request limit.
    directed_rows.push_back(req_row(1'b1, 32'h0000_0200, 16'hFFFF));
    directed_rows.push_back(req_row(1'b0, 32'h0000_0010, 16'd32768));
    directed_rows.push_back(cfg_row(irs_pkg::REG_NUM_NODES, 7'd64));
    directed_rows.push_back(cfg_row(irs_pkg::REG_LOCAL_NODE, 7'd63));
    directed_rows.push_back(typed_row(1'b0, 32'h0000_FC00, 16'd1024, 6'd63, 32'h0000_0000,
                                      1'b1));
    directed_rows.push_back(typed_row(1'b1, 32'h0001_0005, 16'd7, 6'd0, 32'h0000_0405, 1'b0));
    directed_rows.push_back(req_row(1'b1, 32'hFFFF_FFFF, 16'h8000));
    // A node count of zero acts as one; the local id keeps its low six bits
    // and then lies outside the interleave.
    directed_rows.push_back(cfg_row(irs_pkg::REG_NUM_NODES, 7'd0));
    directed_rows.push_back(cfg_row(irs_pkg::REG_LOCAL_NODE, 7'h45));
    directed_rows.push_back(typed_row(1'b0, 32'h0000_1400, 16'd3, 6'd0, 32'h0000_1400, 1'b0));
    // A node count above the maximum is clamped to it.
    directed_rows.push_back(cfg_row(irs_pkg::REG_NUM_NODES, 7'd127));
    directed_rows.push_back(cfg_row(irs_pkg::REG_LOCAL_NODE, 7'd2));
    directed_rows.push_back(typed_row(1'b1, 32'h0000_0800, 16'd1024, 6'd2, 32'h0000_0000,
                                      1'b1));
    directed_rows.push_back(req_row(1'b1, 32'h1234_5678, 16'd5000));
    directed_rows.push_back(cfg_row(irs_pkg::REG_NUM_NODES, 7'd3));
    directed_rows.push_back(cfg_row(irs_pkg::REG_LOCAL_NODE, 7'd1));
    directed_rows.push_back(typed_row(1'b0, 32'h0000_1C00, 16'd16, 6'd1, 32'h0000_0800, 1'b1));
    directed_rows.push_back(req_row(1'b0, 32'hABCD_EF01, 16'h1FFF));
    directed_rows.push_back(req_row(1'b0, 32'hFFFF_FFFF, 16'hFFFF));
    directed_rows.push_back(req_row(1'b1, 32'hFFFF_FFFF, 16'd0));

    // Hold reset, then release it.
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        write_register(directed_rows[i].reg_index, directed_rows[i].reg_value);
      end else begin
        send_request(directed_rows[i].dir, directed_rows[i].offset, directed_rows[i].length,
                     directed_rows[i].typed, directed_rows[i].chunk);
      end
    end

    // Random phases, each under its own interleave setting.
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       nodes = 7'd2;
        1:       nodes = irs_pkg::CFG_DATA_W'($urandom_range(1, 64));
        2:       nodes = 7'd64;
        3:       nodes = irs_pkg::CFG_DATA_W'($urandom_range(0, 127));
        4:       nodes = 7'd1;
        default: nodes = irs_pkg::CFG_DATA_W'($urandom_range(3, 64));
      endcase
      // Mostly a node inside the interleave so that local chunks do occur.
      if ($urandom_range(0, 3) == 0) begin
        home = irs_pkg::CFG_DATA_W'($urandom_range(0, 127));
      end else begin
        home = irs_pkg::CFG_DATA_W'($urandom_range(0,
                 (nodes == 0 || nodes > 64) ? 63 : nodes - 1));
      end
      write_register(irs_pkg::REG_NUM_NODES, nodes);
      write_register(irs_pkg::REG_LOCAL_NODE, home);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        case ($urandom_range(0, 3))
          0:       offset = $urandom();
          1:       offset = 32'hFFFF_F000 | $urandom_range(0, 32'h0FFF);
          2:       offset = ($urandom() & 32'hFFFF_FC00) |
                            (($urandom_range(0, 1) == 1) ? 32'h3FF : 32'h000);
          default: offset = $urandom_range(0, 32'h0010_0000);
        endcase
        pick = $urandom_range(0, 19);
        if (pick < 13) begin
          length = irs_pkg::LEN_W'($urandom_range(1, 2048));
        end else if (pick < 16) begin
          length = irs_pkg::LEN_W'($urandom());
        end else if (pick == 16) begin
          length = '0;
        end else if (pick == 17) begin
          length = 16'd32768;
        end else if (pick == 18) begin
          length = 16'd1024;
        end else begin
          length = irs_pkg::LEN_W'($urandom_range(1, 8));
        end
        send_request(1'($urandom_range(0, 1)), offset, length, 1'b0, none);
      end
    end

    drain_chunks(DRAIN_CYCLES);
    if (mismatch_count == 0) begin
      $display("interleaved_request_splitter_core regression: pass");
    end else begin
      $display("interleaved_request_splitter_core regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ interleaved_request_splitter_core.f @@
design/irs_pkg.sv
design/irs_ctrl.sv
design/irs_datapath.sv
design/interleaved_request_splitter_core.sv
tb/interleaved_request_splitter_core_test.sv
